@@ sv/nearest_table_inverse_search_assert.svh @@
// Assertion macros for the nearest table inverse search block.
// Used by the top level only; no other dependencies.
`ifndef NEAREST_TABLE_INVERSE_SEARCH_ASSERT_SVH
`define NEAREST_TABLE_INVERSE_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, explicit clock and active-low reset
`define NTS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check on the block clock and reset
`define NTS_ASSERT(label, prop, msg) `NTS_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)
`else
`define NTS_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define NTS_ASSERT(label, prop, msg)
`endif
`endif

@@ sv/nts_pkg.sv @@
// Shared types, constants and the sequencer control store for the
// nearest table inverse search block. No dependencies.
package nts_pkg;

    localparam int TABLE_ENTRIES_DEF = 512;

    localparam int SPEED_W = 16;
    localparam int INDEX_W = 9;
    localparam int RATIO_W = 9;

    // stream word layout
    localparam int DIN_W    = 48;
    localparam int DOUT_W   = 16;
    localparam int IDX_LSB  = 0;
    localparam int VAL_LSB  = IDX_LSB + INDEX_W;
    localparam int WANT_LSB = VAL_LSB + SPEED_W;

    // config bus
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam int REG_IDX_W = APB_AW - 2;
    localparam logic [REG_IDX_W-1:0] REG_TABLE_PRESENT = 1'b0;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic signed [SPEED_W-1:0] CLAMP_HI = 16'sd255;
    localparam logic signed [SPEED_W-1:0] CLAMP_LO = -16'sd255;

    typedef enum logic [1:0] {
        STEP_IDLE,
        STEP_READ,
        STEP_EVAL
    } t_step;

    typedef enum logic [1:0] {
        JMP_NEXT,   // unconditional
        JMP_START,  // advance when a search starts
        JMP_LOOP    // back to probe, home when done, hold on output stall
    } t_jmp;

    typedef struct packed {
        logic  accept;
        logic  probe_rd;
        logic  eval;
        t_jmp  jmp;
        t_step next;
    } t_ctrl;

    function automatic t_ctrl ctrl_rom(input t_step step);
        t_ctrl c;
        unique case (step)
            STEP_IDLE: c = '{accept: 1'b1, probe_rd: 1'b0, eval: 1'b0,
                             jmp: JMP_START, next: STEP_READ};
            STEP_READ: c = '{accept: 1'b0, probe_rd: 1'b1, eval: 1'b0,
                             jmp: JMP_NEXT, next: STEP_EVAL};
            STEP_EVAL: c = '{accept: 1'b0, probe_rd: 1'b0, eval: 1'b1,
                             jmp: JMP_LOOP, next: STEP_READ};
            default:   c = '{accept: 1'b0, probe_rd: 1'b0, eval: 1'b0,
                             jmp: JMP_NEXT, next: STEP_IDLE};
        endcase
        return c;
    endfunction

endpackage

@@ sv/nts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/nearest_table_inverse_search.sv @@
// Nearest table inverse search: speed table in RAM, binary search run by a
// small microcoded sequencer. Depends on nts_pkg, nts_ram, the assert header.
//
//  channel  dir  handshake                    word
//  s_axis   in   s_axis_tvalid/tready         op in tuser, entry/speed in tdata
//  m_axis   out  m_axis_tvalid/tready         ratio in tdata
//  apb      in   psel/penable/pwrite, pready  table_present at address 0
//
// A table write, or a search without table (or with zero speed), needs no probe.
// A table search runs a series of probes: each probe is a RAM read and an
// evaluate step, since the next address depends on the registered read data.
// At 512 entries that is at most 9 probes per search.
// Reset is synchronous, active low; the table RAM is not cleared.
// A full output register stalls input acceptance and the final search step.
module nearest_table_inverse_search
    import nts_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [8:0] entry_index, [24:9] entry_value, [40:25] wanted_speed, [47:41] zero
    input  logic [DIN_W-1:0]  s_axis_tdata,
    // [0] op
    input  logic [0:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [8:0] ratio, [15:9] zero
    output logic [DOUT_W-1:0] m_axis_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

`include "nearest_table_inverse_search_assert.svh"

    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int CW   = AW + 2;
    localparam int XW   = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    localparam int HALF = TABLE_ENTRIES / 2;
    localparam int DW   = SPEED_W + 2;
    localparam logic signed [CW-1:0] C_HALF = CW'(HALF);
    localparam logic signed [CW-1:0] C_MAX  = CW'(TABLE_ENTRIES - 1);

    // control state
    t_step r_step, n_step;
    logic  r_out_valid, n_out_valid;
    logic  r_present;

    // datapath
    logic signed [SPEED_W-1:0] r_want;
    logic signed [SPEED_W-1:0] r_last_val;
    logic signed [CW-1:0]      r_cur;
    logic signed [CW-1:0]      r_last;
    logic signed [CW-1:0]      r_jump;
    logic signed [RATIO_W-1:0] r_ratio;

    t_ctrl w_ctrl;

    logic                      w_in_acc;
    logic                      w_slot_free;
    logic                      w_op;
    logic [INDEX_W-1:0]        w_in_idx;
    logic signed [SPEED_W-1:0] w_in_val;
    logic signed [SPEED_W-1:0] w_in_want;
    logic                      w_wr_en;
    logic                      w_start;
    logic                      w_direct;
    logic signed [RATIO_W-1:0] w_direct_ratio;

    logic signed [CW-1:0]      w_diff;
    logic signed [CW-1:0]      w_absdiff;
    logic signed [CW-1:0]      w_clamped;
    logic [SPEED_W-1:0]        w_rd_data;
    logic signed [SPEED_W-1:0] w_val;
    logic signed [DW-1:0]      w_dl, w_dc, w_adl, w_adc;
    logic                      w_final, w_hit, w_done, w_hold;
    logic signed [CW-1:0]      w_pick;
    logic signed [CW-1:0]      w_pick_rel;
    logic                      w_emit;
    logic signed [RATIO_W-1:0] w_emit_ratio;
    logic                      w_cfg_wr;

    assign w_ctrl = ctrl_rom(r_step);

    // input word
    assign w_op      = s_axis_tuser[0];
    assign w_in_idx  = s_axis_tdata[IDX_LSB +: INDEX_W];
    assign w_in_val  = s_axis_tdata[VAL_LSB +: SPEED_W];
    assign w_in_want = s_axis_tdata[WANT_LSB +: SPEED_W];

    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_ctrl.accept && w_slot_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // writes past the table end are dropped
    assign w_wr_en  = w_in_acc && (w_op == OP_WRITE) &&
                      (XW'(w_in_idx) < XW'(TABLE_ENTRIES));
    assign w_start  = w_in_acc && (w_op == OP_SEARCH) && (w_in_want != '0) && r_present;
    assign w_direct = w_in_acc && (w_op == OP_SEARCH) && !w_start;

    always_comb begin
        if (w_in_want > CLAMP_HI) begin
            w_direct_ratio = RATIO_W'(CLAMP_HI);
        end else if (w_in_want < CLAMP_LO) begin
            w_direct_ratio = RATIO_W'(CLAMP_LO);
        end else begin
            w_direct_ratio = RATIO_W'(w_in_want);
        end
    end

    // probe step: jump from the unclamped index, address from the clamped one
    assign w_diff    = r_cur - r_last;
    assign w_absdiff = (w_diff < 0) ? -w_diff : w_diff;
    always_comb begin
        if (r_cur < 0) begin
            w_clamped = '0;
        end else if (r_cur > C_MAX) begin
            w_clamped = C_MAX;
        end else begin
            w_clamped = r_cur;
        end
    end

    nts_ram #(
        .WIDTH (SPEED_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(w_in_idx)),
        .i_wr_data (w_in_val),
        .i_rd_en   (w_ctrl.probe_rd),
        .i_rd_addr (w_clamped[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // evaluate step
    assign w_val   = w_rd_data;
    assign w_dl    = DW'(r_last_val) - DW'(r_want);
    assign w_dc    = DW'(w_val) - DW'(r_want);
    assign w_adl   = (w_dl < 0) ? -w_dl : w_dl;
    assign w_adc   = (w_dc < 0) ? -w_dc : w_dc;
    assign w_final = (r_jump == '0);
    assign w_hit   = (r_want == w_val);
    assign w_done  = w_ctrl.eval && (w_final || w_hit);
    assign w_hold  = w_done && !w_slot_free;
    // tie goes to the current probe
    assign w_pick     = (w_final && (w_adl < w_adc)) ? r_last : r_cur;
    assign w_pick_rel = w_pick - C_HALF;

    assign w_emit       = w_direct || (w_done && w_slot_free);
    assign w_emit_ratio = w_direct ? w_direct_ratio : RATIO_W'(w_pick_rel);

    // sequencer
    always_comb begin
        unique case (w_ctrl.jmp)
            JMP_NEXT:  n_step = w_ctrl.next;
            JMP_START: n_step = w_start ? w_ctrl.next : r_step;
            JMP_LOOP: begin
                if (w_hold) begin
                    n_step = r_step;
                end else if (w_done) begin
                    n_step = STEP_IDLE;
                end else begin
                    n_step = w_ctrl.next;
                end
            end
            default:   n_step = STEP_IDLE;
        endcase
    end

    always_comb begin
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[APB_AW-1:2] == REG_TABLE_PRESENT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_out_valid <= 1'b0;
            r_present   <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                r_present <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_want     <= w_in_want;
            r_cur      <= C_HALF;
            r_last     <= '0;
            r_last_val <= '0;
        end else if (w_ctrl.probe_rd) begin
            r_cur  <= w_clamped;
            r_jump <= w_absdiff >>> 1;
        end else if (w_ctrl.eval && !w_done) begin
            r_last     <= r_cur;
            r_last_val <= w_val;
            if (r_want > w_val) begin
                r_cur <= r_cur + r_jump;
            end else begin
                r_cur <= r_cur - r_jump;
            end
        end
        if (w_emit) begin
            r_ratio <= w_emit_ratio;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DOUT_W'($unsigned(r_ratio));
    assign pready        = 1'b1;
    assign prdata        = (paddr[APB_AW-1:2] == REG_TABLE_PRESENT) ?
                           APB_DW'(r_present) : '0;

    `NTS_ASSERT(a_busy_no_accept, (r_step != STEP_IDLE) |-> !s_axis_tready, "accept during search")
    `NTS_ASSERT(a_read_then_eval, (r_step == STEP_READ) |=> (r_step == STEP_EVAL), "probe read not evaluated")
    `NTS_ASSERT(a_probe_in_range, (r_step == STEP_EVAL) |-> ((r_cur >= 0) && (r_cur <= C_MAX)), "probe out of table")
    `NTS_ASSERT(a_emit_slot_free, w_emit |-> (!r_out_valid || m_axis_tready), "result overwritten")

endmodule
